// ===== rtl/core/jsc_pkg.sv =====
// types and constants shared by the fixed json schema checker modules
package jsc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 16;

   localparam logic [BYTE_W-1:0] CHR_OPEN_BRACE  = 8'h7B;
   localparam logic [BYTE_W-1:0] CHR_CLOSE_BRACE = 8'h7D;
   localparam logic [BYTE_W-1:0] CHR_COLON       = 8'h3A;
   localparam logic [BYTE_W-1:0] CHR_COMMA       = 8'h2C;
   localparam logic [BYTE_W-1:0] CHR_QUOTE       = 8'h22;
   localparam logic [BYTE_W-1:0] CHR_ZERO        = 8'h30;
   localparam logic [BYTE_W-1:0] CHR_NINE        = 8'h39;
   localparam logic [BYTE_W-1:0] CHR_SPACE       = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_TAB         = 8'h09;
   localparam logic [BYTE_W-1:0] CHR_NEWLINE     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_RETURN      = 8'h0D;

   typedef enum logic [12:0] {
      PH_OPEN   = 13'b0_0000_0000_0001,
      PH_KEY1   = 13'b0_0000_0000_0010,
      PH_COLON1 = 13'b0_0000_0000_0100,
      PH_VAL1   = 13'b0_0000_0000_1000,
      PH_COMMA  = 13'b0_0000_0001_0000,
      PH_KEY2   = 13'b0_0000_0010_0000,
      PH_COLON2 = 13'b0_0000_0100_0000,
      PH_DIG1   = 13'b0_0000_1000_0000,
      PH_DIG2   = 13'b0_0001_0000_0000,
      PH_DIG3   = 13'b0_0010_0000_0000,
      PH_CLOSE  = 13'b0_0100_0000_0000,
      PH_DONE   = 13'b0_1000_0000_0000,
      PH_ERROR  = 13'b1_0000_0000_0000
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [COUNT_W-1:0] count;
      logic               finished;
   } parse_state_type;

   typedef struct packed {
      logic               syntax_valid;
      logic               rejected;
      logic [COUNT_W-1:0] bytes_counted;
   } result_type;

endpackage

// ===== rtl/core/jsc_step.sv =====
// one byte of parse: next phase, saturating count and result decision
module jsc_step import jsc_pkg::*; (
   input  logic [BYTE_W-1:0]  data_byte,
   input  logic               first_of_stream,
   input  logic               last_of_stream,
   input  logic [COUNT_W-1:0] count_cap,
   input  parse_state_type    state_cur,
   output parse_state_type    state_next,
   output logic               emit,
   output result_type         result
);

   parse_state_type base;
   phase_type       phase_step;
   logic            is_space;
   logic            is_digit;

   always_comb begin
      is_space = (data_byte == CHR_SPACE) || (data_byte == CHR_TAB) ||
                 (data_byte == CHR_NEWLINE) || (data_byte == CHR_RETURN);
      is_digit = (data_byte >= CHR_ZERO) && (data_byte <= CHR_NINE);
   end

   always_comb begin
      if (first_of_stream) begin
         base.phase    = PH_OPEN;
         base.count    = '0;
         base.finished = 1'b0;
      end else begin
         base = state_cur;
      end
   end

   always_comb begin
      unique case (base.phase)
         PH_OPEN:   phase_step = (data_byte == CHR_OPEN_BRACE) ? PH_KEY1 : PH_ERROR;
         PH_KEY1:   phase_step = (data_byte == CHR_QUOTE) ? PH_COLON1 : PH_ERROR;
         PH_COLON1: phase_step = (data_byte == CHR_COLON) ? PH_VAL1 : PH_COLON1;
         PH_VAL1:   phase_step = (data_byte == CHR_QUOTE) ? PH_COMMA : PH_VAL1;
         PH_COMMA: begin
            if (data_byte == CHR_COMMA) begin
               phase_step = PH_KEY2;
            end else if (data_byte == CHR_CLOSE_BRACE) begin
               phase_step = PH_DONE;
            end else begin
               phase_step = PH_COMMA;
            end
         end
         PH_KEY2:   phase_step = (data_byte == CHR_QUOTE) ? PH_COLON2 : PH_KEY2;
         PH_COLON2: phase_step = (data_byte == CHR_COLON) ? PH_DIG1 : PH_COLON2;
         PH_DIG1:   phase_step = is_digit ? PH_DIG2 : PH_ERROR;
         PH_DIG2:   phase_step = is_digit ? PH_DIG3 : PH_ERROR;
         PH_DIG3:   phase_step = is_digit ? PH_CLOSE : PH_ERROR;
         PH_CLOSE:  phase_step = (data_byte == CHR_CLOSE_BRACE) ? PH_DONE : PH_ERROR;
         default:   phase_step = base.phase;
      endcase
   end

   always_comb begin
      state_next = base;
      emit       = 1'b0;
      if (!base.finished) begin
         if (base.count < count_cap) begin
            state_next.count = base.count + COUNT_W'(1);
         end
         if (!is_space) begin
            state_next.phase = phase_step;
         end
         emit = (state_next.phase == PH_DONE) || (state_next.phase == PH_ERROR) ||
                last_of_stream;
         state_next.finished = emit;
      end

      result.syntax_valid  = (state_next.phase == PH_DONE);
      result.rejected      = (state_next.phase == PH_ERROR);
      result.bytes_counted = state_next.count;
   end

endmodule

// ===== rtl/core/fixed_json_schema_checker.sv =====
// path: a byte is held in the input register; a result that ends its parse goes to the result register
// throughput: one byte per cycle while the result side does not stall
// the input register and the parse state advance only when the result register is free
// reset: synchronous, active high; parse restarts awaiting open brace, count zero
module fixed_json_schema_checker import jsc_pkg::*; #(
   parameter longint unsigned MAX_STREAM_BYTES = 65535
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_first_of_stream,
   input  logic               req_last_of_stream,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_syntax_valid,
   output logic               rsp_rejected,
   output logic [COUNT_W-1:0] rsp_bytes_counted
);

   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (MAX_STREAM_BYTES < 64'(2**COUNT_W - 1)) ? COUNT_W'(MAX_STREAM_BYTES) : '1;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_data_ff;
   logic              in_first_ff;
   logic              in_last_ff;

   parse_state_type   state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;

   parse_state_type   step_state;
   logic              step_emit;
   result_type        step_result;
   logic              advance;
   logic              req_take;

   jsc_step u_step (
      .data_byte       (in_data_ff),
      .first_of_stream (in_first_ff),
      .last_of_stream  (in_last_ff),
      .count_cap       (COUNT_CAP),
      .state_cur       (state_ff),
      .state_next      (step_state),
      .emit            (step_emit),
      .result          (step_result)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      state_in = advance ? step_state : state_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = step_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         state_ff.phase    <= PH_OPEN;
         state_ff.count    <= '0;
         state_ff.finished <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff  <= req_data_byte;
         in_first_ff <= req_first_of_stream;
         in_last_ff  <= req_last_of_stream;
      end
      if (advance && step_emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_syntax_valid  = rsp_ff.syntax_valid;
   assign rsp_rejected      = rsp_ff.rejected;
   assign rsp_bytes_counted = rsp_ff.bytes_counted;

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.phase))
      else $error("parse phase not one-hot");

   a_end_sets_finished: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_DONE || state_ff.phase == PH_ERROR) |-> state_ff.finished)
      else $error("parse ended without finished flag");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.syntax_valid && rsp_ff.rejected))
      else $error("result both valid and rejected");

   a_result_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.bytes_counted != '0 && rsp_ff.bytes_counted <= COUNT_CAP))
      else $error("result byte count out of range");

endmodule
